### rtl/adpcm_pkg.sv
// Shared types and constants for the ADPCM frame decoder.
// Used by adpcm_front, adpcm_fifo, adpcm_back and dsp_adpcm_frame_decoder.
package adpcm_pkg;

  localparam int BYTE_W      = 8;
  localparam int NIB_W       = 4;
  localparam int SCALE_W     = 4;
  localparam int SEL_W       = 3;
  localparam int POS_W       = 3;
  localparam int SAMPLE_W    = 16;
  localparam int COEF_W      = 16;
  localparam int PROD_W      = 2 * COEF_W;
  localparam int SUM_W       = 34;
  localparam int SHAMT_W     = 5;
  localparam int FRAC_SHIFT  = 11;
  localparam int NUM_PAIRS   = 8;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;

  localparam logic signed [SUM_W-1:0] ROUND_TERM = SUM_W'(1024);
  localparam logic signed [SUM_W-1:0] SAT_MIN    = -SUM_W'(32768);
  localparam logic signed [SUM_W-1:0] SAT_MAX    = SUM_W'(32767);
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_BANK_A   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BANK_B   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BANK_C   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BANK_D   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_HIST_NEW = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_HIST_OLD = 3'd6;

  // One data byte with the frame parameters that apply to it.
  typedef struct packed {
    logic [BYTE_W-1:0]  data_byte;
    logic [SCALE_W-1:0] scale;
    logic [SEL_W-1:0]   sel;
  } adpcm_entry_t;

  typedef struct packed {
    logic         push;
    adpcm_entry_t entry;
  } adpcm_push_t;

  typedef struct packed {
    logic         valid;
    adpcm_entry_t entry;
  } adpcm_head_t;

endpackage

### rtl/adpcm_front.sv
// Front end: takes input bytes, tracks frame position and header fields,
// and pushes data bytes into the queue. Depends on adpcm_pkg.
module adpcm_front #(
  parameter int DATA_BYTES_PER_FRAME = 7
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [7:0]                   s_tdata,
  input  logic                         s_tuser,
  input  logic                         fifo_full,
  output adpcm_pkg::adpcm_push_t       push
);
  import adpcm_pkg::*;

  logic [POS_W-1:0]   pos;
  logic [SCALE_W-1:0] scale;
  logic [SEL_W-1:0]   sel;
  logic               accept;
  logic               is_header;

  assign s_tready  = ~fifo_full;
  assign accept    = s_tvalid & s_tready;
  assign is_header = s_tuser | (pos == '0);

  assign push.push            = accept & ~is_header;
  assign push.entry.data_byte = s_tdata;
  assign push.entry.scale     = scale;
  assign push.entry.sel       = sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      scale <= '0;
      sel   <= '0;
    end else if (accept) begin
      if (is_header) begin
        // Bit 7 of the header is dropped from the pair select.
        scale <= s_tdata[SCALE_W-1:0];
        sel   <= s_tdata[SCALE_W +: SEL_W];
        pos   <= POS_W'(1);
      end else if (pos >= POS_W'(DATA_BYTES_PER_FRAME)) begin
        pos <= '0;
      end else begin
        pos <= pos + POS_W'(1);
      end
    end
  end

endmodule

### rtl/adpcm_fifo.sv
// Short queue of data bytes between front end and decode back end.
// Depends on adpcm_pkg.
module adpcm_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  adpcm_pkg::adpcm_push_t push,
  input  logic                   pop,
  output logic                   full,
  output adpcm_pkg::adpcm_head_t head
);
  import adpcm_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  adpcm_entry_t   store [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign full       = (count == CW'(DEPTH));
  assign head.valid = (count != '0);
  assign head.entry = store[rd_ptr];
  assign do_push    = push.push & ~full;
  assign do_pop     = pop & head.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

### rtl/adpcm_back.sv
// Back end: decodes one nibble per cycle against the sample history while a byte
// is queued and the result register is free, then applies the output gain in a
// second stage. Holds the configuration registers. Depends on adpcm_pkg.
module adpcm_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [adpcm_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [adpcm_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  adpcm_pkg::adpcm_head_t               head,
  output logic                                 pop,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [15:0]                          m_tdata,
  output logic                                 m_tlast
);
  import adpcm_pkg::*;

  logic [2*COEF_W-1:0]         coef_pair [NUM_PAIRS];
  logic signed [SAMPLE_W-1:0]  gain;
  logic signed [SAMPLE_W-1:0]  hist_new;
  logic signed [SAMPLE_W-1:0]  hist_old;
  logic                        phase;

  logic [2*COEF_W-1:0]         pair;
  logic signed [COEF_W-1:0]    coef_a;
  logic signed [COEF_W-1:0]    coef_b;
  logic signed [NIB_W-1:0]     nib;
  logic [SHAMT_W-1:0]          shamt;
  logic signed [PROD_W-1:0]    pred_a;
  logic signed [PROD_W-1:0]    pred_b;
  logic signed [SUM_W-1:0]     nib_term;
  logic signed [SUM_W-1:0]     sum;
  logic signed [SUM_W-1:0]     shifted;
  logic signed [SAMPLE_W-1:0]  dec;

  logic                        res_valid;
  logic signed [SAMPLE_W-1:0]  res_sample;
  logic                        res_last;
  logic signed [PROD_W-1:0]    gained;

  logic                        out_load;
  logic                        res_free;
  logic                        fire;

  // Stage 1: prediction and reconstruction for the current nibble.
  assign pair   = coef_pair[head.entry.sel];
  assign coef_a = signed'(pair[COEF_W-1:0]);
  assign coef_b = signed'(pair[2*COEF_W-1:COEF_W]);
  assign nib    = phase ? signed'(head.entry.data_byte[NIB_W-1:0])
                        : signed'(head.entry.data_byte[BYTE_W-1:NIB_W]);
  assign shamt  = SHAMT_W'(head.entry.scale) + SHAMT_W'(FRAC_SHIFT);
  assign pred_a = coef_a * hist_new;
  assign pred_b = coef_b * hist_old;

  always_comb begin
    nib_term = signed'({{(SUM_W-NIB_W){nib[NIB_W-1]}}, nib}) <<< shamt;
    sum      = nib_term + ROUND_TERM
             + signed'({{(SUM_W-PROD_W){pred_a[PROD_W-1]}}, pred_a})
             + signed'({{(SUM_W-PROD_W){pred_b[PROD_W-1]}}, pred_b});
    shifted  = sum >>> FRAC_SHIFT;
    if (shifted < SAT_MIN) begin
      dec = SAMPLE_MIN;
    end else if (shifted > SAT_MAX) begin
      dec = SAMPLE_MAX;
    end else begin
      dec = shifted[SAMPLE_W-1:0];
    end
  end

  // The result register frees up whenever the output register can load.
  assign out_load = ~m_tvalid | m_tready;
  assign res_free = ~res_valid | out_load;
  assign fire     = head.valid & res_free;
  assign pop      = fire & phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PAIRS; i++) begin
        coef_pair[i] <= '0;
      end
      gain     <= SAMPLE_W'(1);
      hist_new <= '0;
      hist_old <= '0;
      phase    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index) inside
          REG_BANK_A, REG_BANK_B, REG_BANK_C, REG_BANK_D: begin
            coef_pair[{cfg_index[1:0], 1'b0}] <= cfg_data[2*COEF_W-1:0];
            coef_pair[{cfg_index[1:0], 1'b1}] <= cfg_data[CFG_DATA_W-1:2*COEF_W];
          end
          REG_GAIN:     gain     <= signed'(cfg_data[SAMPLE_W-1:0]);
          REG_HIST_NEW: hist_new <= signed'(cfg_data[SAMPLE_W-1:0]);
          REG_HIST_OLD: hist_old <= signed'(cfg_data[SAMPLE_W-1:0]);
          default: ;
        endcase
      end
      if (fire) begin
        hist_old <= hist_new;
        hist_new <= dec;
        phase    <= ~phase;
      end
    end
  end

  // Stage 2: gain multiply into the output register.
  assign gained = res_sample * gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (res_free) begin
        res_valid <= fire;
      end
      if (out_load) begin
        m_tvalid <= res_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_sample <= dec;
      res_last   <= phase;
    end
    if (out_load && res_valid) begin
      m_tdata <= gained[SAMPLE_W-1:0];
      m_tlast <= res_last;
    end
  end

  // The queue entry stays in place until its low nibble is decoded.
  a_entry_held: assert property (@(posedge clk) disable iff (rst)
    phase |-> head.valid)
    else $error("decode phase set with no queued byte");

  a_pop_on_low: assert property (@(posedge clk) disable iff (rst)
    pop |-> (phase && res_free))
    else $error("queue popped outside the low-nibble step");

  a_result_kept: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !out_load) |=> (res_valid && $stable(res_sample)))
    else $error("stalled decoded sample was lost");

  a_low_follows_high: assert property (@(posedge clk) disable iff (rst)
    (fire && !phase) |=> phase)
    else $error("high nibble not followed by low nibble");

endmodule

### rtl/dsp_adpcm_frame_decoder.sv
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tdata[7:0] data_byte, s_tuser range_start
// m_*       out  m_tvalid/m_tready  m_tdata[15:0] pcm_sample, m_tlast pair_last
// cfg_*     in   cfg_we             cfg_index register, cfg_data value
//
// A header byte is taken and yields nothing; a data byte is decoded one nibble at
// a time in the decode stage, high nibble first, serialised by the history
// recurrence. Each sample passes the result register, then the output register.
// Reset is synchronous and needs no clearing pass; the queue decouples the
// input from output stalls until it fills.
// Top level of the ADPCM frame decoder; depends on adpcm_pkg, adpcm_front,
// adpcm_fifo and adpcm_back.
module dsp_adpcm_frame_decoder #(
  parameter int DATA_BYTES_PER_FRAME = 7,  // 1 to 7
  parameter int QUEUE_DEPTH          = 4   // 2 or more
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,   // [7:0] data_byte
  input  logic                              s_tuser,   // [0] range_start
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [15:0]                       m_tdata,   // [15:0] pcm_sample
  output logic                              m_tlast,
  input  logic                              cfg_we,
  input  logic [adpcm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [adpcm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import adpcm_pkg::*;

  adpcm_push_t push;
  adpcm_head_t head;
  logic        fifo_full;
  logic        pop;

  adpcm_front #(
    .DATA_BYTES_PER_FRAME(DATA_BYTES_PER_FRAME)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .fifo_full(fifo_full),
    .push     (push)
  );

  adpcm_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk (clk),
    .rst (rst),
    .push(push),
    .pop (pop),
    .full(fifo_full),
    .head(head)
  );

  adpcm_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
